@@ sv/jhd_pkg.sv @@
package jhd_pkg;

	localparam int NUM_TABLES_DEF = 8;
	localparam int CODE_LEN       = 16;
	localparam int SYM_NUM        = 256;

	typedef enum logic [1:0] {
		CMD_LOAD_COUNT  = 2'd0,
		CMD_LOAD_SYMBOL = 2'd1,
		CMD_DECODE      = 2'd2,
		CMD_CLEAR       = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic [2:0] table_select;
		logic [7:0] entry_index;
		logic [7:0] entry_value;
		logic       code_bit;
	} in_item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic [4:0] code_length;
		logic       unmatched;
	} out_item_t;

	typedef struct packed {
		logic       cnt_we;
		logic       sym_we;
		logic       clr;
		logic [2:0] tbl;
		logic [7:0] index;
		logic [7:0] value;
	} tbl_wr_t;

	function automatic logic [4:0] top_length(input logic [CODE_LEN-1:0] m);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < CODE_LEN; i++) begin
			if (m[i]) r = 5'(i + 1);
		end
		return r;
	endfunction

endpackage

@@ sv/jhd_stream_if.sv @@
interface jhd_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ sv/jhd_table_store.sv @@
module jhd_table_store import jhd_pkg::*; #(
	parameter int NUM_TABLES = NUM_TABLES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  tbl_wr_t    wr,
	input  logic       rd_en,
	input  logic [2:0] rd_table,
	input  logic [3:0] rd_idx_b,
	output logic [7:0] cnt_a,
	output logic [7:0] cnt_b,
	input  logic [2:0] q_table,
	input  logic [3:0] q_idx,
	output logic       q_nonzero,
	output logic [4:0] q_longest,
	input  logic       sym_re,
	input  logic [2:0] sym_table,
	input  logic [7:0] sym_pos,
	output logic [7:0] sym_data
);

	localparam int TW = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;

	logic [7:0]          cnt_mem [NUM_TABLES][CODE_LEN];
	logic [7:0]          sym_mem [NUM_TABLES][SYM_NUM];
	logic [CODE_LEN-1:0] nz_mask_q [NUM_TABLES];
	logic [7:0]          cnt_a_q;
	logic [7:0]          cnt_b_q;
	logic [7:0]          sym_q;

	always_ff @(posedge clk) begin
		if (wr.cnt_we) cnt_mem[wr.tbl[TW-1:0]][wr.index[3:0]] <= wr.value;
		if (rd_en) begin
			cnt_a_q <= cnt_mem[rd_table[TW-1:0]][4'd0];
			cnt_b_q <= cnt_mem[rd_table[TW-1:0]][rd_idx_b];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.sym_we) sym_mem[wr.tbl[TW-1:0]][wr.index] <= wr.value;
		if (sym_re) sym_q <= sym_mem[sym_table[TW-1:0]][sym_pos];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TABLES; t++) nz_mask_q[t] <= '0;
		end else if (wr.clr) begin
			nz_mask_q[wr.tbl[TW-1:0]] <= '0;
		end else if (wr.cnt_we) begin
			nz_mask_q[wr.tbl[TW-1:0]][wr.index[3:0]] <= (wr.value != 8'd0);
		end
	end

	assign cnt_a     = cnt_a_q;
	assign cnt_b     = cnt_b_q;
	assign sym_data  = sym_q;
	assign q_nonzero = nz_mask_q[q_table[TW-1:0]][q_idx];
	assign q_longest = top_length(nz_mask_q[q_table[TW-1:0]]);

endmodule

@@ sv/jpeg_huffman_symbol_decoder.sv @@
// Canonical JPEG Huffman decoder, one command per cycle when the result side keeps up.
// A code bit that finishes a symbol passes the s2 stage, then the response registers.
// Throughput: one item per cycle while the result side keeps up; the count memory reads
// the restart and the next length in parallel so consecutive bits need no bubble.
// Reset clears the decoder progress and the per-table nonzero-count masks; count and
// symbol memories are not cleared and hold undefined data until written.
module jpeg_huffman_symbol_decoder import jhd_pkg::*; #(
	parameter int NUM_TABLES = NUM_TABLES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	jhd_stream_if.sink   req,
	jhd_stream_if.source rsp
);

	localparam logic [3:0] TABLE_LIMIT = 4'(NUM_TABLES);

	in_item_t  item;
	logic      advance;
	logic      accept;
	logic      tvalid_in;
	tbl_wr_t   wr;
	logic [3:0] rd_idx_b;

	logic       dec_s2;
	logic [2:0] table_s2;
	logic       tvalid_s2;
	logic       bit_s2;

	logic [15:0] acc_q;
	logic [16:0] fc_q;
	logic [8:0]  sb_q;
	logic [4:0]  bt_q;

	logic        rsp_valid_q;
	logic [4:0]  code_length_q;
	logic        unmatched_q;

	logic [7:0]  cnt_a;
	logic [7:0]  cnt_b;
	logic        q_nonzero;
	logic [4:0]  q_longest;
	logic [7:0]  sym_data;

	logic [15:0] acc_next;
	logic [4:0]  n;
	logic [4:0]  lng;
	logic [4:0]  lng_eff;
	logic [7:0]  cnt;
	logic [16:0] diff;
	logic        match;
	logic        done;
	logic [7:0]  pos;
	logic        load;

	assign item      = req.data;
	assign advance   = !rsp_valid_q || rsp.ready;
	assign req.ready = advance;
	assign accept    = req.valid && advance;
	assign tvalid_in = {1'b0, item.table_select} < TABLE_LIMIT;

	always_comb begin
		wr        = '0;
		wr.tbl    = item.table_select;
		wr.index  = item.entry_index;
		wr.value  = item.entry_value;
		if (accept && tvalid_in) begin
			unique case (item.command)
				CMD_LOAD_COUNT:  wr.cnt_we = (item.entry_index[7:4] == 4'd0);
				CMD_LOAD_SYMBOL: wr.sym_we = 1'b1;
				CMD_CLEAR:       wr.clr    = 1'b1;
				CMD_DECODE:      wr        = wr;
				default:         wr        = wr;
			endcase
		end
	end

	// predict the length index the next bit needs if the bit in flight continues
	assign rd_idx_b = dec_s2 ? (bt_q[3:0] + 4'd1) : bt_q[3:0];

	always_comb begin
		acc_next = {acc_q[14:0], bit_s2};
		n        = bt_q + 5'd1;
		lng      = tvalid_s2 ? q_longest : 5'd0;
		lng_eff  = (lng == 5'd0) ? 5'd1 : lng;
		cnt      = (tvalid_s2 && q_nonzero) ? ((bt_q == 5'd0) ? cnt_a : cnt_b) : 8'd0;
		diff     = {1'b0, acc_next} - fc_q;
		match    = ({1'b0, acc_next} >= fc_q) && (diff < {9'd0, cnt});
		done     = match || (n >= lng_eff);
		pos      = sb_q[7:0] + diff[7:0];
	end

	assign load = advance && dec_s2 && done;

	jhd_table_store #(.NUM_TABLES(NUM_TABLES)) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.rd_en     (accept),
		.rd_table  (item.table_select),
		.rd_idx_b  (rd_idx_b),
		.cnt_a     (cnt_a),
		.cnt_b     (cnt_b),
		.q_table   (table_s2),
		.q_idx     (bt_q[3:0]),
		.q_nonzero (q_nonzero),
		.q_longest (q_longest),
		.sym_re    (load),
		.sym_table (table_s2),
		.sym_pos   (pos),
		.sym_data  (sym_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_s2 <= 1'b0;
		end else if (advance) begin
			dec_s2 <= accept && (item.command == CMD_DECODE);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			table_s2  <= item.table_select;
			tvalid_s2 <= tvalid_in;
			bit_s2    <= item.code_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			fc_q  <= '0;
			sb_q  <= '0;
			bt_q  <= '0;
		end else if (advance && dec_s2) begin
			if (done) begin
				acc_q <= '0;
				fc_q  <= '0;
				sb_q  <= '0;
				bt_q  <= '0;
			end else begin
				acc_q <= acc_next;
				fc_q  <= (fc_q + {9'd0, cnt}) << 1;
				sb_q  <= sb_q + {1'b0, cnt};
				bt_q  <= n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= dec_s2 && done;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_length_q <= n;
			unmatched_q   <= !match;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.data.symbol      = unmatched_q ? 8'd0 : sym_data;
	assign rsp.data.code_length = code_length_q;
	assign rsp.data.unmatched   = unmatched_q;

endmodule
